// ----- design/mpint_pkg.sv -----
// types, constants and helpers shared by the msgpack integer decoder
// no dependencies
`default_nettype none

package mpint_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned LEFT_W  = 4;

    // tag bytes and masks of the format
    localparam logic [7:0] POS_FIX_MASK = 8'h80;
    localparam logic [7:0] NEG_FIX_MASK = 8'hE0;
    localparam logic [7:0] FIX_VAL_MASK = 8'h1F;
    localparam logic [7:0] TAG_UINT8    = 8'hCC;
    localparam logic [7:0] TAG_UINT16   = 8'hCD;
    localparam logic [7:0] TAG_UINT32   = 8'hCE;
    localparam logic [7:0] TAG_UINT64   = 8'hCF;
    localparam logic [7:0] TAG_INT8     = 8'hD0;
    localparam logic [7:0] TAG_INT16    = 8'hD1;
    localparam logic [7:0] TAG_INT32    = 8'hD2;
    localparam logic [7:0] TAG_INT64    = 8'hD3;

    typedef enum logic [1:0] {
        TAG_POS_FIX,
        TAG_NEG_FIX,
        TAG_PAYLOAD,
        TAG_BAD
    } t_tag_class;

    // payload size code: 0..3 for 1, 2, 4, 8 bytes
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_4 = 2'd2,
        LEN_8 = 2'd3
    } t_len_code;

    typedef struct packed {
        t_tag_class tag_class;
        t_len_code  len_code;
        logic       is_signed;
    } t_tag_info;

    function automatic logic [LEFT_W-1:0] len_bytes(input t_len_code code);
        logic [LEFT_W-1:0] n;
        unique case (code)
            LEN_1:   n = LEFT_W'(1);
            LEN_2:   n = LEFT_W'(2);
            LEN_4:   n = LEFT_W'(4);
            LEN_8:   n = LEFT_W'(8);
            default: n = LEFT_W'(1);
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- design/mpint_in_if.sv -----
// input channel of the msgpack integer decoder: one stream byte per word
// depends on mpint_pkg
`default_nettype none

interface mpint_in_if;
    logic                              valid;
    logic                              ready;
    logic [mpint_pkg::BYTE_W-1:0]      in_byte;
    logic [mpint_pkg::KIND_W-1:0]      target_kind;

    modport source (output valid, output in_byte, output target_kind, input ready);
    modport sink   (input valid, input in_byte, input target_kind, output ready);
endinterface

`default_nettype wire

// ----- design/mpint_out_if.sv -----
// result channel of the msgpack integer decoder: one decoded value per word
// depends on mpint_pkg
`default_nettype none

interface mpint_out_if;
    logic                              valid;
    logic                              ready;
    logic [mpint_pkg::VALUE_W-1:0]     value_bits;
    logic                              tag_error;

    modport source (output valid, output value_bits, output tag_error, input ready);
    modport sink   (input valid, input value_bits, input tag_error, output ready);
endinterface

`default_nettype wire

// ----- design/mpint_tag_decode.sv -----
// classifies a tag byte against the wanted destination kind
// depends on mpint_pkg
`default_nettype none

module mpint_tag_decode (
    input  wire logic [mpint_pkg::BYTE_W-1:0] i_tag,
    input  wire logic [mpint_pkg::KIND_W-1:0] i_kind,
    output mpint_pkg::t_tag_info              o_info
);

    logic [1:0] size;
    logic [1:0] idx;
    logic       kind_signed;
    logic       is_uint_tag;
    logic       is_int_tag;

    assign size        = i_kind[1:0];
    assign kind_signed = i_kind[2];
    assign idx         = i_tag[1:0];
    assign is_uint_tag = (i_tag[7:2] == mpint_pkg::TAG_UINT8[7:2]);
    assign is_int_tag  = (i_tag[7:2] == mpint_pkg::TAG_INT8[7:2]);

    always_comb begin
        o_info.tag_class = mpint_pkg::TAG_BAD;
        o_info.len_code  = mpint_pkg::t_len_code'(idx);
        o_info.is_signed = 1'b0;
        priority if ((i_tag & mpint_pkg::POS_FIX_MASK) == 8'h00) begin
            o_info.tag_class = mpint_pkg::TAG_POS_FIX;
        end else if (((i_tag & mpint_pkg::NEG_FIX_MASK) == mpint_pkg::NEG_FIX_MASK)
                     && kind_signed) begin
            o_info.tag_class = mpint_pkg::TAG_NEG_FIX;
        end else if (!kind_signed) begin
            if (is_uint_tag && (idx <= size)) begin
                o_info.tag_class = mpint_pkg::TAG_PAYLOAD;
            end
        end else if (is_int_tag && (idx <= size)) begin
            o_info.tag_class = mpint_pkg::TAG_PAYLOAD;
            o_info.is_signed = 1'b1;
        end else if (is_uint_tag && (idx < size)) begin
            // a signed kind takes an unsigned format of any smaller size
            o_info.tag_class = mpint_pkg::TAG_PAYLOAD;
        end else begin
            o_info.tag_class = mpint_pkg::TAG_BAD;
        end
    end

endmodule

`default_nettype wire

// ----- design/msgpack_integer_decoder_core.sv -----
// msgpack integer decoder top level: tag state, payload accumulator, result register
// depends on mpint_pkg, mpint_in_if, mpint_out_if, mpint_tag_decode
//
// usage:
//   i_in carries the stream one byte per word, with the wanted destination kind
//   (0..3 u8..u64, 4..7 i8..i64) that is looked at only on a tag byte.
//   o_out carries one word per decoded integer: value_bits, extended to 64 bits
//   by the format, and tag_error for a tag the kind does not allow (value zero).
//   a fixint or a rejected tag gives its result in the cycle after it is taken;
//   a payload format gives its result in the cycle after its last payload byte.
//   bytes go in at one per cycle unless the receiver stalls: the tag check and the
//   accumulator shift sit between the input handshake and the result register.
//   a byte is taken whenever the result register is empty or is being read in
//   the same cycle, so a stalled receiver holds the result and the input waits.
//   synchronous active-low reset empties the result register and returns the
//   decoder to waiting for a tag.
`default_nettype none

module msgpack_integer_decoder_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mpint_in_if.sink    i_in,
    mpint_out_if.source o_out
);

    localparam int unsigned VW = mpint_pkg::VALUE_W;
    localparam int unsigned LW = mpint_pkg::LEFT_W;
    localparam int unsigned BW = mpint_pkg::BYTE_W;

    mpint_pkg::t_tag_info info;

    logic [LW-1:0]          r_bytes_left, n_bytes_left;
    logic [VW-1:0]          r_gathered, n_gathered;
    logic                   r_sgn, n_sgn;
    mpint_pkg::t_len_code   r_len_code, n_len_code;
    logic                   r_out_valid, n_out_valid;
    logic [VW-1:0]          r_value, n_value;
    logic                   r_bad, n_bad;

    logic                   accept;
    logic                   emit;
    logic [VW-1:0]          shifted;
    logic [VW-1:0]          extended;

    mpint_tag_decode u_tag (
        .i_tag  (i_in.in_byte),
        .i_kind (i_in.target_kind),
        .o_info (info)
    );

    assign i_in.ready       = !r_out_valid || o_out.ready;
    assign accept           = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.value_bits = r_value;
    assign o_out.tag_error  = r_bad;

    assign shifted = {r_gathered[VW-BW-1:0], i_in.in_byte};

    // sign extension by payload length for signed formats
    always_comb begin
        extended = shifted;
        if (r_sgn) begin
            unique case (r_len_code)
                mpint_pkg::LEN_1: extended = {{(VW-8){shifted[7]}}, shifted[7:0]};
                mpint_pkg::LEN_2: extended = {{(VW-16){shifted[15]}}, shifted[15:0]};
                mpint_pkg::LEN_4: extended = {{(VW-32){shifted[31]}}, shifted[31:0]};
                mpint_pkg::LEN_8: extended = shifted;
                default:          extended = shifted;
            endcase
        end
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_gathered   = r_gathered;
        n_sgn        = r_sgn;
        n_len_code   = r_len_code;
        n_value      = r_value;
        n_bad        = r_bad;
        emit         = 1'b0;
        if (accept) begin
            if (r_bytes_left != '0) begin
                n_bytes_left = r_bytes_left - LW'(1);
                n_gathered   = shifted;
                if (r_bytes_left == LW'(1)) begin
                    emit       = 1'b1;
                    n_value    = extended;
                    n_bad      = 1'b0;
                    n_gathered = '0;
                end
            end else begin
                unique case (info.tag_class)
                    mpint_pkg::TAG_POS_FIX: begin
                        emit    = 1'b1;
                        n_value = VW'(i_in.in_byte);
                        n_bad   = 1'b0;
                    end
                    mpint_pkg::TAG_NEG_FIX: begin
                        emit    = 1'b1;
                        n_value = {{(VW-BW){1'b1}}, i_in.in_byte};
                        n_bad   = 1'b0;
                    end
                    mpint_pkg::TAG_PAYLOAD: begin
                        n_bytes_left = mpint_pkg::len_bytes(info.len_code);
                        n_len_code   = info.len_code;
                        n_sgn        = info.is_signed;
                        n_gathered   = '0;
                    end
                    mpint_pkg::TAG_BAD: begin
                        emit    = 1'b1;
                        n_value = '0;
                        n_bad   = 1'b1;
                    end
                    default: begin
                        emit    = 1'b1;
                        n_value = '0;
                        n_bad   = 1'b1;
                    end
                endcase
            end
        end
        n_out_valid = emit || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_gathered   <= '0;
            r_sgn        <= 1'b0;
            r_len_code   <= mpint_pkg::LEN_1;
            r_out_valid  <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_gathered   <= n_gathered;
            r_sgn        <= n_sgn;
            r_len_code   <= n_len_code;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_bad   <= n_bad;
    end

    // an error word never carries a value
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bad |-> r_value == '0)
        else $error("error word with nonzero value");

    // payload count stays within the longest format
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= LW'(8))
        else $error("payload count out of range");

    // each payload byte taken counts down by one
    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_bytes_left != '0) |=> r_bytes_left == $past(r_bytes_left) - LW'(1))
        else $error("payload count did not step");

    // a payload byte short of the last produces no word
    a_no_early_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_bytes_left > LW'(1)) && o_out.ready |=> !r_out_valid)
        else $error("word produced before last payload byte");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input blocked with empty result register");

endmodule

`default_nettype wire
